// ===== rtl/tcpopt_pkg.sv =====
package tcpopt_pkg;

  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_SACKOK = 8'd4;
  localparam logic [7:0] KIND_TSTAMP = 8'd8;

  localparam logic [3:0] LEN_SINGLE = 4'd1;
  localparam logic [3:0] LEN_MSS    = 4'd4;
  localparam logic [3:0] LEN_WSCALE = 4'd3;
  localparam logic [3:0] LEN_SACKOK = 4'd2;
  localparam logic [3:0] LEN_TSTAMP = 4'd10;

  localparam logic [3:0] OFF_MSS_HI   = 4'd2;
  localparam logic [3:0] OFF_MSS_LO   = 4'd3;
  localparam logic [3:0] OFF_SACK_LEN = 4'd1;
  localparam logic [3:0] OFF_TS_FIRST = 4'd2;
  localparam logic [3:0] OFF_TS_LAST  = 4'd5;
  localparam logic [3:0] OFF_WS_SHIFT = 4'd2;

  localparam logic [7:0] SACK_LEN_BYTE = 8'd2;
  localparam logic [7:0] MAX_SHIFT     = 8'd14;

  localparam int unsigned WIN_W    = 16;
  localparam int unsigned SCALED_W = 30;

  typedef enum logic [2:0] {
    CAP_NONE = 3'd0,
    CAP_MSS  = 3'd1,
    CAP_SACK = 3'd2,
    CAP_TS   = 3'd3,
    CAP_WS   = 3'd4
  } cap_e;

  typedef struct packed {
    logic [7:0]       option_byte;
    logic             last_byte;
    logic [WIN_W-1:0] header_window;
  } opt_beat_t;

  typedef struct packed {
    logic      valid;
    opt_beat_t beat;
  } stage_t;

  typedef struct packed {
    logic [3:0]  skip;
    cap_e        cap;
    logic [3:0]  off;
    logic        ended;
    logic [15:0] mss;
    logic        mss_seen;
    logic [7:0]  shift;
    logic        sack;
    logic [31:0] tsval;
    logic        ts_seen;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '0;

  typedef struct packed {
    logic [15:0] mss;
    logic        mss_found;
    logic [7:0]  shift;
    logic        sack;
    logic [31:0] tsval;
    logic        ts_found;
  } opt_summary_t;

endpackage

// ===== rtl/tcpopt_if.sv =====
interface tcpopt_opt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  option_byte;
  logic        last_byte;
  logic [15:0] header_window;

  modport source (output valid, option_byte, last_byte, header_window, input ready);
  modport sink   (input valid, option_byte, last_byte, header_window, output ready);
endinterface

interface tcpopt_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_segment_size;
  logic        mss_found;
  logic [7:0]  window_shift;
  logic        sack_allowed;
  logic [31:0] timestamp_value;
  logic        timestamp_found;
  logic [29:0] scaled_window;

  modport source (output valid, max_segment_size, mss_found, window_shift, sack_allowed,
                  timestamp_value, timestamp_found, scaled_window, input ready);
  modport sink   (input valid, max_segment_size, mss_found, window_shift, sack_allowed,
                  timestamp_value, timestamp_found, scaled_window, output ready);
endinterface

// ===== rtl/tcpopt_in_reg.sv =====
module tcpopt_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  tcpopt_opt_if.sink         opt_i,
  input  logic               adv_i,
  output tcpopt_pkg::stage_t stage_o
);
  import tcpopt_pkg::*;

  logic      valid_q, valid_d;
  opt_beat_t beat_q;
  logic      load;

  assign opt_i.ready = !valid_q || adv_i;
  assign load        = opt_i.valid && opt_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (opt_i.ready) begin
      valid_d = opt_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q.option_byte   <= opt_i.option_byte;
      beat_q.last_byte     <= opt_i.last_byte;
      beat_q.header_window <= opt_i.header_window;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.beat  = beat_q;

endmodule

// ===== rtl/tcpopt_parse.sv =====
module tcpopt_parse (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     take_i,
  input  tcpopt_pkg::opt_beat_t    beat_i,
  output tcpopt_pkg::opt_summary_t summary_o
);
  import tcpopt_pkg::*;

  parse_state_t state_q, state_d, upd;
  logic [7:0]   b;
  logic [3:0]   len;
  cap_e         cap;

  assign b = beat_i.option_byte;

  always_comb begin
    upd = state_q;
    len = LEN_SINGLE;
    cap = CAP_NONE;
    if (!state_q.ended) begin
      if (state_q.skip != '0) begin
        unique case (state_q.cap)
          CAP_MSS: begin
            if (state_q.off == OFF_MSS_HI) begin
              upd.mss_seen = 1'b0;
              upd.mss      = {b, 8'h00};
            end else if (state_q.off == OFF_MSS_LO) begin
              upd.mss[7:0] = b;
              upd.mss_seen = 1'b1;
            end
          end
          CAP_SACK: begin
            if (state_q.off == OFF_SACK_LEN && b == SACK_LEN_BYTE) begin
              upd.sack = 1'b1;
            end
          end
          CAP_TS: begin
            if (state_q.off >= OFF_TS_FIRST && state_q.off <= OFF_TS_LAST) begin
              if (state_q.off == OFF_TS_FIRST) begin
                upd.ts_seen = 1'b0;
              end
              upd.tsval = {state_q.tsval[23:0], b};
              if (state_q.off == OFF_TS_LAST) begin
                upd.ts_seen = 1'b1;
              end
            end
          end
          CAP_WS: begin
            if (state_q.off == OFF_WS_SHIFT) begin
              upd.shift = b;
            end
          end
          default: ;
        endcase
        upd.off  = state_q.off + 4'd1;
        upd.skip = state_q.skip - 4'd1;
        if (upd.skip == '0) begin
          upd.cap = CAP_NONE;
        end
      end else if (b == KIND_EOL) begin
        upd.ended = 1'b1;
      end else begin
        unique case (b)
          KIND_MSS: begin
            len = LEN_MSS;
            cap = CAP_MSS;
          end
          KIND_SACKOK: begin
            len = LEN_SACKOK;
            cap = CAP_SACK;
          end
          KIND_TSTAMP: begin
            len = LEN_TSTAMP;
            cap = CAP_TS;
          end
          KIND_WSCALE: begin
            len = LEN_WSCALE;
            cap = CAP_WS;
          end
          default: ;
        endcase
        upd.skip = len - 4'd1;
        upd.cap  = cap;
        upd.off  = 4'd1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    if (take_i) begin
      state_d = beat_i.last_byte ? PARSE_RESET : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PARSE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  assign summary_o.mss       = upd.mss_seen ? upd.mss : '0;
  assign summary_o.mss_found = upd.mss_seen;
  assign summary_o.shift     = upd.shift;
  assign summary_o.sack      = upd.sack;
  assign summary_o.tsval     = upd.ts_seen ? upd.tsval : '0;
  assign summary_o.ts_found  = upd.ts_seen;

  a_idle_no_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.skip == '0 |-> state_q.cap == CAP_NONE)
    else $error("capture kind set with no bytes owed");

  a_ended_no_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ended |-> state_q.skip == '0)
    else $error("parsing ended inside an option");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && beat_i.last_byte |=> state_q == PARSE_RESET)
    else $error("state not cleared after last beat");

endmodule

// ===== rtl/tcpopt_out_reg.sv =====
module tcpopt_out_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  tcpopt_pkg::opt_summary_t summary_i,
  input  logic [15:0]              window_i,
  output logic                     free_o,
  tcpopt_res_if.source             res_o
);
  import tcpopt_pkg::*;

  logic                valid_q, valid_d;
  opt_summary_t        sum_q;
  logic [SCALED_W-1:0] scaled_q, scaled_d, win_ext;
  logic [3:0]          sh;

  assign sh       = (summary_i.shift > MAX_SHIFT) ? MAX_SHIFT[3:0] : summary_i.shift[3:0];
  assign win_ext  = {{(SCALED_W - WIN_W){1'b0}}, window_i};
  assign scaled_d = win_ext << sh;

  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q    <= summary_i;
      scaled_q <= scaled_d;
    end
  end

  assign res_o.valid            = valid_q;
  assign res_o.max_segment_size = sum_q.mss;
  assign res_o.mss_found        = sum_q.mss_found;
  assign res_o.window_shift     = sum_q.shift;
  assign res_o.sack_allowed     = sum_q.sack;
  assign res_o.timestamp_value  = sum_q.tsval;
  assign res_o.timestamp_found  = sum_q.ts_found;
  assign res_o.scaled_window    = scaled_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result loaded over an unread beat");

endmodule

// ===== rtl/tcp_option_parser_core.sv =====
// TCP option parser. Takes the options area one byte per beat and, on the beat
// flagged last_byte, returns one result beat with the MSS, window scale shift,
// SACK-permitted flag, TSval and the header window scaled by min(shift, 14).
// Each byte is registered, walked through the option state in one step, and a
// result is registered behind it; a new byte is accepted each cycle unless the
// input stalls, as it does only while a last byte waits for the output
// register to be drained. The result beat is presented by the output register,
// loaded from the input register. State returns to reset after each last byte.
module tcp_option_parser_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcpopt_opt_if.sink   opt_i,
  tcpopt_res_if.source res_o
);
  import tcpopt_pkg::*;

  stage_t       s1;
  opt_summary_t summary;
  logic         out_free;
  logic         take;
  logic         load;

  assign take = s1.valid && (!s1.beat.last_byte || out_free);
  assign load = take && s1.beat.last_byte;

  tcpopt_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .opt_i   (opt_i),
    .adv_i   (take),
    .stage_o (s1)
  );

  tcpopt_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .beat_i    (s1.beat),
    .summary_o (summary)
  );

  tcpopt_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .summary_i (summary),
    .window_i  (s1.beat.header_window),
    .free_o    (out_free),
    .res_o     (res_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !opt_i.ready |-> s1.valid && s1.beat.last_byte && res_o.valid && !res_o.ready)
    else $error("input stalled without a blocked result");

endmodule
